// ===== rtl/pbe_pkg.sv =====
package pbe_pkg;

  localparam int PATCH_DIM   = 3;
  localparam int NUM_POINTS  = PATCH_DIM * PATCH_DIM;
  localparam int NUM_COORDS  = 5;
  localparam int STORE_DEPTH = NUM_POINTS * NUM_COORDS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int PARAM_W = 17;
  localparam int ONE_Q16 = 65536;

  // datapath widths
  localparam int WGT_W  = 19;
  localparam int PROD_W = 51;
  localparam int ROW_W  = 52;
  localparam int RND_W  = ROW_W - 16;
  localparam int TOT_W  = 54;
  localparam int RES_W  = TOT_W - 16;
  localparam int VEC_W  = 52;
  localparam int SV_W   = 25;
  localparam int ROOT_W = 64;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_EVAL = 1'b1;

  localparam int NRM_ONE = 16384;

  typedef logic signed [31:0]      word_t;
  typedef logic signed [RES_W-1:0] res_t;
  typedef logic signed [WGT_W-1:0] wgt_t;
  typedef logic signed [15:0]      nrm_t;

  function automatic word_t sat32(input res_t v);
    logic hi_same;
    hi_same = (v[RES_W-1:31] == '0) || (v[RES_W-1:31] == '1);
    if (hi_same) return v[31:0];
    else if (v[RES_W-1]) return 32'sh8000_0000;
    else return 32'sh7fff_ffff;
  endfunction

endpackage

// ===== rtl/biquadratic_bezier_patch_eval.sv =====
// Biquadratic Bezier patch evaluator. The 3x3 control points (x, y, z, s, t in
// signed Q16.16) sit in a 45-word synchronous RAM, five words per point. A load
// transaction (tuser = 0) writes one point; an index above 8 is dropped. An
// evaluate transaction (tuser = 1) returns one result: the blended point and
// texture coordinate, saturated to 32 bits, and the unit normal in Q2.14 (zero
// when degenerate). An evaluate streams the 45 RAM reads through the
// multiply-accumulate pipeline, then runs the normal unit, which normalizes by
// one-bit shifts, takes a bit-serial square root and divides each component
// bit by bit. One item is worked at a time; a finished result waits in the
// output register while the next item is taken. Points must be loaded before
// they are evaluated.
module biquadratic_bezier_patch_eval import pbe_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // point_index[3:0], ctrl_x, ctrl_y, ctrl_z, ctrl_s, ctrl_t, param_u[16:0],
  // param_v[16:0], zero fill
  input  logic [199:0] s_tdata,
  // action
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // point_x, point_y, point_z, tex_s, tex_t, normal_x, normal_y, normal_z
  output logic [207:0] m_tdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_BLEND = 3'd2;
  localparam logic [2:0] ST_NORM  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state;
  logic       s_acc;

  logic [3:0] ld_idx;
  logic [2:0] ld_cnt;
  word_t      ld_data [NUM_COORDS];

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  word_t             wdata, rdata;

  logic [PARAM_W-1:0] pu_in, pv_in, pu_c, pv_c;
  logic  blend_start, blend_done, norm_start, norm_done;
  word_t pt [NUM_COORDS];
  res_t  da [3], db [3];
  nrm_t  nrm [3];

  word_t out_pt [NUM_COORDS];
  nrm_t  out_n [3];

  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;

  assign pu_in = s_tdata[180:164];
  assign pv_in = s_tdata[197:181];
  assign pu_c  = (pu_in > PARAM_W'(ONE_Q16)) ? PARAM_W'(ONE_Q16) : pu_in;
  assign pv_c  = (pv_in > PARAM_W'(ONE_Q16)) ? PARAM_W'(ONE_Q16) : pv_in;

  assign blend_start = s_acc && (s_tuser[0] == ACTION_EVAL);
  assign norm_start  = (state == ST_BLEND) && blend_done;

  assign we    = (state == ST_LOAD);
  assign waddr = ADDR_W'(ld_idx) * ADDR_W'(NUM_COORDS) + ADDR_W'(ld_cnt);
  assign wdata = ld_data[ld_cnt];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            if (s_tuser[0] == ACTION_EVAL) state <= ST_BLEND;
            else if (s_tdata[3:0] < 4'(NUM_POINTS)) state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (ld_cnt == 3'(NUM_COORDS - 1)) state <= ST_IDLE;
        end
        ST_BLEND: begin
          if (blend_done) state <= ST_NORM;
        end
        ST_NORM: begin
          if (norm_done) state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      ld_idx     <= s_tdata[3:0];
      ld_cnt     <= '0;
      ld_data[0] <= s_tdata[35:4];
      ld_data[1] <= s_tdata[67:36];
      ld_data[2] <= s_tdata[99:68];
      ld_data[3] <= s_tdata[131:100];
      ld_data[4] <= s_tdata[163:132];
    end else if (state == ST_LOAD) begin
      ld_cnt <= ld_cnt + 3'd1;
    end
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      out_pt <= pt;
      out_n  <= nrm;
    end
  end

  assign m_tdata = {out_n[2], out_n[1], out_n[0], out_pt[4], out_pt[3], out_pt[2],
                    out_pt[1], out_pt[0]};

  pbe_ram #(
    .WIDTH(32),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  pbe_blend u_blend (
    .clk  (clk),
    .rst  (rst),
    .start(blend_start),
    .pu   (pu_c),
    .pv   (pv_c),
    .raddr(raddr),
    .rdata(rdata),
    .done (blend_done),
    .pt   (pt),
    .a    (da),
    .b    (db)
  );

  pbe_norm u_norm (
    .clk  (clk),
    .rst  (rst),
    .start(norm_start),
    .a    (da),
    .b    (db),
    .done (norm_done),
    .nrm  (nrm)
  );

`ifndef SYNTHESIS
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (waddr < ADDR_W'(STORE_DEPTH)))
    else $error("store write beyond last entry");

  a_blend_done_state: assert property (@(posedge clk) disable iff (rst)
    blend_done |-> (state == ST_BLEND))
    else $error("blend finished outside an evaluate");

  a_norm_done_state: assert property (@(posedge clk) disable iff (rst)
    norm_done |-> (state == ST_NORM))
    else $error("normal finished outside an evaluate");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_OUT))
    else $error("result raised without a finished evaluate");
`endif

endmodule

// ===== rtl/pbe_ram.sv =====
module pbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 45
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pbe_blend.sv =====
module pbe_blend import pbe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PARAM_W-1:0] pu,
  input  logic [PARAM_W-1:0] pv,
  output logic [ADDR_W-1:0] raddr,
  input  word_t             rdata,
  output logic              done,
  output word_t             pt [NUM_COORDS],
  output res_t              a [3],
  output res_t              b [3]
);

  logic [PARAM_W-1:0] pu_r, pv_r;

  // basis squares, one per cycle through a shared multiplier
  logic                 setup_act;
  logic [1:0]           setup_cnt;
  logic [PARAM_W-1:0]   sq_op;
  logic [33:0]          sq_p;
  logic                 sq_v;
  logic [1:0]           sq_tag;
  logic [33:0]          sq_rnd;
  logic [PARAM_W-1:0]   sqw [4];

  wgt_t wu [3], du [3], wv [3], dv [3];
  wgt_t pu_s, pv_s, one_s;

  // read sequencer
  logic       running;
  logic [1:0] j_i, k_i;
  logic [2:0] c_i;

  logic       v1, v2, v3, v4;
  logic [1:0] j1, k1, j2, k2, k3, k4;
  logic [2:0] c1, c2, c3, c4;

  logic signed [PROD_W-1:0] prod_p, prod_d;
  logic signed [ROW_W-1:0]  row_p, row_d, sum_p, sum_d, rs_p, rs_d;
  logic signed [RND_W-1:0]  rnd_p, rnd_d;
  logic signed [TOT_W-1:0]  m_p, m_a, m_b, tot_p, tot_a, tot_b;
  logic signed [TOT_W-1:0]  ts_p, ts_a, ts_b, tr_p, tr_a, tr_b;

  always_comb begin
    case (setup_cnt)
      2'd0:    sq_op = PARAM_W'(ONE_Q16) - pu_r;
      2'd1:    sq_op = pu_r;
      2'd2:    sq_op = PARAM_W'(ONE_Q16) - pv_r;
      default: sq_op = pv_r;
    endcase
  end

  assign sq_rnd = sq_p + 34'd32768;

  always_comb begin
    one_s = WGT_W'(ONE_Q16);
    pu_s  = $signed({2'b00, pu_r});
    pv_s  = $signed({2'b00, pv_r});
    wu[0] = $signed({2'b00, sqw[0]});
    wu[2] = $signed({2'b00, sqw[1]});
    wu[1] = one_s - wu[0] - wu[2];
    wv[0] = $signed({2'b00, sqw[2]});
    wv[2] = $signed({2'b00, sqw[3]});
    wv[1] = one_s - wv[0] - wv[2];
    du[0] = -((one_s - pu_s) <<< 1);
    du[1] = (one_s - (pu_s <<< 1)) <<< 1;
    du[2] = pu_s <<< 1;
    dv[0] = -((one_s - pv_s) <<< 1);
    dv[1] = (one_s - (pv_s <<< 1)) <<< 1;
    dv[2] = pv_s <<< 1;
  end

  assign raddr = (ADDR_W'(j_i) + ADDR_W'(k_i) * ADDR_W'(PATCH_DIM)) * ADDR_W'(NUM_COORDS)
               + ADDR_W'(c_i);

  always_ff @(posedge clk) begin
    if (rst) begin
      setup_act <= 1'b0;
      setup_cnt <= '0;
      sq_v      <= 1'b0;
      running   <= 1'b0;
      j_i       <= '0;
      k_i       <= '0;
      c_i       <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      done      <= 1'b0;
    end else begin
      sq_v <= setup_act;
      if (start) begin
        setup_act <= 1'b1;
        setup_cnt <= '0;
      end else if (setup_act) begin
        setup_cnt <= setup_cnt + 2'd1;
        if (setup_cnt == 2'd3) setup_act <= 1'b0;
      end
      if (sq_v && sq_tag == 2'd3) begin
        running <= 1'b1;
        j_i     <= '0;
        k_i     <= '0;
        c_i     <= '0;
      end else if (running) begin
        if (j_i == 2'd2) begin
          j_i <= '0;
          if (k_i == 2'd2) begin
            k_i <= '0;
            if (c_i == 3'(NUM_COORDS - 1)) running <= 1'b0;
            else c_i <= c_i + 3'd1;
          end else begin
            k_i <= k_i + 2'd1;
          end
        end else begin
          j_i <= j_i + 2'd1;
        end
      end
      v1 <= running;
      v2 <= v1;
      v3 <= v2 && (j2 == 2'd2);
      v4 <= v3;
      done <= v4 && (k4 == 2'd2) && (c4 == 3'(NUM_COORDS - 1));
    end
  end

  assign sum_p = (j2 == 2'd0) ? ROW_W'(prod_p) : row_p + ROW_W'(prod_p);
  assign sum_d = (j2 == 2'd0) ? ROW_W'(prod_d) : row_d + ROW_W'(prod_d);
  assign rs_p  = sum_p + ROW_W'(32768);
  assign rs_d  = sum_d + ROW_W'(32768);

  assign ts_p = (k4 == 2'd0) ? m_p : tot_p + m_p;
  assign ts_a = (k4 == 2'd0) ? m_a : tot_a + m_a;
  assign ts_b = (k4 == 2'd0) ? m_b : tot_b + m_b;
  assign tr_p = ts_p + TOT_W'(32768);
  assign tr_a = ts_a + TOT_W'(32768);
  assign tr_b = ts_b + TOT_W'(32768);

  always_ff @(posedge clk) begin
    if (start) begin
      pu_r <= pu;
      pv_r <= pv;
    end
    sq_p   <= sq_op * sq_op;
    sq_tag <= setup_cnt;
    if (sq_v) sqw[sq_tag] <= sq_rnd[32:16];

    j1 <= j_i;
    k1 <= k_i;
    c1 <= c_i;
    prod_p <= rdata * wu[j1];
    prod_d <= rdata * du[j1];
    j2 <= j1;
    k2 <= k1;
    c2 <= c1;
    if (v2) begin
      row_p <= sum_p;
      row_d <= sum_d;
    end
    rnd_p <= rs_p[ROW_W-1:16];
    rnd_d <= rs_d[ROW_W-1:16];
    k3 <= k2;
    c3 <= c2;
    m_p <= rnd_p * wv[k3];
    m_b <= rnd_p * dv[k3];
    m_a <= rnd_d * wv[k3];
    k4 <= k3;
    c4 <= c3;
    if (v4) begin
      tot_p <= ts_p;
      tot_a <= ts_a;
      tot_b <= ts_b;
      if (k4 == 2'd2) begin
        pt[c4] <= sat32(tr_p[TOT_W-1:16]);
        if (c4 < 3'd3) begin
          a[c4[1:0]] <= tr_a[TOT_W-1:16];
          b[c4[1:0]] <= tr_b[TOT_W-1:16];
        end
      end
    end
  end

endmodule

// ===== rtl/pbe_norm.sv =====
module pbe_norm import pbe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  res_t a [3],
  input  res_t b [3],
  output logic done,
  output nrm_t nrm [3]
);

  localparam logic [3:0] N_IDLE  = 4'd0;
  localparam logic [3:0] N_MAG   = 4'd1;
  localparam logic [3:0] N_SCALE = 4'd2;
  localparam logic [3:0] N_CROSS = 4'd3;
  localparam logic [3:0] N_SQ    = 4'd4;
  localparam logic [3:0] N_ROOT  = 4'd5;
  localparam logic [3:0] N_DINIT = 4'd6;
  localparam logic [3:0] N_DIV   = 4'd7;
  localparam logic [3:0] N_DONE  = 4'd8;

  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;

  logic [3:0] state;
  logic [1:0] phase;
  logic [2:0] cnt;
  logic [4:0] dcnt;
  logic [1:0] di;

  logic signed [VEC_W-1:0] v [3];
  logic [VEC_W-1:0]        mag [3];
  logic [VEC_W-1:0]        m, mag_max;
  logic                    too_big, too_small;

  logic signed [SV_W-1:0]  sa [3], sb [3];
  logic signed [SV_W-1:0]  op_a, op_b;
  logic signed [2*SV_W-1:0] xp;
  logic                    xp_v;
  logic [2:0]              xp_tag;

  // a floor shift of a negative component can reach a magnitude of 2^30
  logic [30:0]      cm [3];
  logic             neg [3];
  logic [61:0]      sq;
  logic             sq_v;
  logic [ROOT_W-1:0] rs, rr, rbit, rtry;

  logic [30:0] len;
  logic [45:0] rem, dsh;
  logic [15:0] q, qc;

  always_comb begin
    for (int i = 0; i < 3; i++) mag[i] = v[i][VEC_W-1] ? VEC_W'(-v[i]) : VEC_W'(v[i]);
    mag_max = mag[0];
    if (mag[1] > mag_max) mag_max = mag[1];
    if (mag[2] > mag_max) mag_max = mag[2];
  end

  // target magnitude is 24 bits for the derivatives and 30 for the cross product
  assign too_big   = (phase == PH_C) ? (m[VEC_W-1:30] != '0) : (m[VEC_W-1:24] != '0);
  assign too_small = (phase == PH_C) ? (m[VEC_W-1:29] == '0) : (m[VEC_W-1:23] == '0);

  always_comb begin
    case (cnt)
      3'd0:    begin op_a = sa[1]; op_b = sb[2]; end
      3'd1:    begin op_a = sa[2]; op_b = sb[1]; end
      3'd2:    begin op_a = sa[2]; op_b = sb[0]; end
      3'd3:    begin op_a = sa[0]; op_b = sb[2]; end
      3'd4:    begin op_a = sa[0]; op_b = sb[1]; end
      default: begin op_a = sa[1]; op_b = sb[0]; end
    endcase
  end

  assign rtry = rr + rbit;
  assign len  = rr[30:0];
  assign qc   = (q > 16'(NRM_ONE)) ? 16'(NRM_ONE) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
      xp_v  <= 1'b0;
      sq_v  <= 1'b0;
    end else begin
      done <= (state == N_DONE);
      xp_v <= (state == N_CROSS) && (cnt < 3'd6);
      sq_v <= (state == N_SQ) && (cnt < 3'd3);
      case (state)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) v[i] <= VEC_W'(a[i]);
            phase <= PH_A;
            state <= N_MAG;
          end
        end
        N_MAG: begin
          m     <= mag_max;
          state <= N_SCALE;
        end
        N_SCALE: begin
          if (m != '0 && too_big) begin
            for (int i = 0; i < 3; i++) v[i] <= v[i] >>> 1;
            m <= m >> 1;
          end else if (m != '0 && too_small) begin
            for (int i = 0; i < 3; i++) v[i] <= v[i] <<< 1;
            m <= m << 1;
          end else begin
            case (phase)
              PH_A: begin
                for (int i = 0; i < 3; i++) begin
                  sa[i] <= v[i][SV_W-1:0];
                  v[i]  <= VEC_W'(b[i]);
                end
                phase <= PH_B;
                state <= N_MAG;
              end
              PH_B: begin
                for (int i = 0; i < 3; i++) sb[i] <= v[i][SV_W-1:0];
                cnt   <= '0;
                state <= N_CROSS;
              end
              default: begin
                if (m == '0) begin
                  for (int i = 0; i < 3; i++) nrm[i] <= '0;
                  state <= N_DONE;
                end else begin
                  for (int i = 0; i < 3; i++) begin
                    cm[i]  <= mag[i][30:0];
                    neg[i] <= v[i][VEC_W-1];
                  end
                  cnt   <= '0;
                  rs    <= '0;
                  rr    <= '0;
                  rbit  <= ROOT_W'(1) << 62;
                  state <= N_SQ;
                end
              end
            endcase
          end
        end
        N_CROSS: begin
          if (cnt < 3'd6) begin
            xp     <= op_a * op_b;
            xp_tag <= cnt;
            cnt    <= cnt + 3'd1;
          end else begin
            phase <= PH_C;
            state <= N_MAG;
          end
          if (xp_v) begin
            if (!xp_tag[0]) v[xp_tag[2:1]] <= VEC_W'(xp);
            else v[xp_tag[2:1]] <= v[xp_tag[2:1]] - VEC_W'(xp);
          end
        end
        N_SQ: begin
          if (cnt < 3'd3) begin
            sq  <= cm[cnt[1:0]] * cm[cnt[1:0]];
            cnt <= cnt + 3'd1;
          end else begin
            state <= N_ROOT;
          end
          if (sq_v) rs <= rs + ROOT_W'(sq);
        end
        N_ROOT: begin
          if (rs >= rtry) begin
            rs <= rs - rtry;
            rr <= (rr >> 1) + rbit;
          end else begin
            rr <= rr >> 1;
          end
          rbit <= rbit >> 2;
          if (rbit == ROOT_W'(1)) begin
            di    <= '0;
            state <= N_DINIT;
          end
        end
        N_DINIT: begin
          rem   <= 46'({cm[di], 14'b0}) + 46'(len >> 1);
          dsh   <= 46'(len) << 15;
          q     <= '0;
          dcnt  <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          if (dcnt == 5'd16) begin
            nrm[di] <= neg[di] ? -$signed(qc) : $signed(qc);
            if (di == 2'd2) state <= N_DONE;
            else begin
              di    <= di + 2'd1;
              state <= N_DINIT;
            end
          end else begin
            if (rem >= dsh) begin
              rem <= rem - dsh;
              q   <= {q[14:0], 1'b1};
            end else begin
              q <= {q[14:0], 1'b0};
            end
            dsh  <= dsh >> 1;
            dcnt <= dcnt + 5'd1;
          end
        end
        N_DONE: begin
          state <= N_IDLE;
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/tb_biquadratic_bezier_patch_eval.sv =====
module tb_biquadratic_bezier_patch_eval;
  import pbe_pkg::*;

  typedef longint trio_t [3];

  typedef struct {
    logic signed [31:0] px, py, pz, ts, tt;
    logic signed [15:0] nx, ny, nz;
  } patch_res_t;

  localparam int IDLE_LIMIT = 20000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [199:0] s_tdata;
  logic [0:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [207:0] m_tdata;

  biquadratic_bezier_patch_eval dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // shadow of the control point memory, entry 5*point + coord
  longint     ctrl_mem [STORE_DEPTH];
  patch_res_t surface_q [$];
  int         mismatch_cnt;
  int         burst_left;
  bit         rx_hold;
  int         rx_stall_pct;
  int         n_loads, n_evals, n_results, n_degenerate;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic longint round16(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic void bernstein(longint p, output trio_t w, output trio_t d);
    longint q;
    q = ONE_Q16 - p;
    w[0] = (q * q + 32768) >>> 16;
    w[2] = (p * p + 32768) >>> 16;
    w[1] = ONE_Q16 - w[0] - w[2];
    d[0] = -2 * q;
    d[1] = 2 * (ONE_Q16 - 2 * p);
    d[2] = 2 * p;
  endfunction

  function automatic longint blend_coord(int c, trio_t wu, trio_t wv);
    longint total, row;
    total = 0;
    for (int k = 0; k < 3; k++) begin
      row = 0;
      for (int j = 0; j < 3; j++) row += ctrl_mem[(j + 3 * k) * NUM_COORDS + c] * wu[j];
      total += round16(row) * wv[k];
    end
    return round16(total);
  endfunction

  function automatic longint unsigned abs64(longint x);
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  // shift so the largest magnitude is exactly target bits wide
  function automatic void fit_bits(ref trio_t v, input int target);
    longint unsigned m;
    int len;
    m = abs64(v[0]);
    if (abs64(v[1]) > m) m = abs64(v[1]);
    if (abs64(v[2]) > m) m = abs64(v[2]);
    len = 0;
    while (m != 0) begin
      len++;
      m = m >> 1;
    end
    if (len == 0) return;
    for (int i = 0; i < 3; i++)
      if (len > target) v[i] = v[i] >>> (len - target);
      else v[i] = v[i] <<< (target - len);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic patch_res_t eval_patch(longint pu, longint pv);
    patch_res_t r;
    trio_t wu, du, wv, dv, a, b, c;
    longint unsigned sq, len, q;
    if (pu > ONE_Q16) pu = ONE_Q16;
    if (pv > ONE_Q16) pv = ONE_Q16;
    bernstein(pu, wu, du);
    bernstein(pv, wv, dv);
    r.px = clamp32(blend_coord(0, wu, wv));
    r.py = clamp32(blend_coord(1, wu, wv));
    r.pz = clamp32(blend_coord(2, wu, wv));
    r.ts = clamp32(blend_coord(3, wu, wv));
    r.tt = clamp32(blend_coord(4, wu, wv));
    for (int i = 0; i < 3; i++) begin
      a[i] = blend_coord(i, du, wv);
      b[i] = blend_coord(i, wu, dv);
    end
    fit_bits(a, 24);
    fit_bits(b, 24);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    fit_bits(c, 30);
    r.nx = 0;
    r.ny = 0;
    r.nz = 0;
    if (c[0] != 0 || c[1] != 0 || c[2] != 0) begin
      sq = 0;
      for (int i = 0; i < 3; i++) sq += abs64(c[i]) * abs64(c[i]);
      len = floor_sqrt(sq);
      for (int i = 0; i < 3; i++) begin
        q = (abs64(c[i]) * 16384 + len / 2) / len;
        if (q > NRM_ONE) q = NRM_ONE;
        if (i == 0) r.nx = (c[i] < 0) ? -q[15:0] : q[15:0];
        if (i == 1) r.ny = (c[i] < 0) ? -q[15:0] : q[15:0];
        if (i == 2) r.nz = (c[i] < 0) ? -q[15:0] : q[15:0];
      end
    end else begin
      n_degenerate++;
    end
    return r;
  endfunction

  // ---------------- sender ----------------
  task automatic send_item(input logic act, input logic [3:0] idx,
                           input logic [31:0] x, y, z, s, t,
                           input logic [16:0] u, v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tuser  <= act;
    s_tdata  <= {2'b0, v, u, t, s, z, y, x, idx};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (act == ACTION_LOAD) begin
      n_loads++;
      if (idx < NUM_POINTS) begin
        ctrl_mem[idx * NUM_COORDS + 0] = longint'(signed'(x));
        ctrl_mem[idx * NUM_COORDS + 1] = longint'(signed'(y));
        ctrl_mem[idx * NUM_COORDS + 2] = longint'(signed'(z));
        ctrl_mem[idx * NUM_COORDS + 3] = longint'(signed'(s));
        ctrl_mem[idx * NUM_COORDS + 4] = longint'(signed'(t));
      end
    end else begin
      n_evals++;
      surface_q.push_back(eval_patch(longint'(u), longint'(v)));
    end
  endtask

  task automatic load_pt(input int idx, input logic [31:0] x, y, z, s, t);
    send_item(ACTION_LOAD, idx[3:0], x, y, z, s, t, 17'($urandom), 17'($urandom));
  endtask

  task automatic eval_at(input logic [16:0] u, v);
    send_item(ACTION_EVAL, 4'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
              u, v);
  endtask

  task automatic wait_drained;
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (surface_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord;
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic logic [16:0] rand_param;
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // ---------------- tests ----------------
  task automatic test_field_extremes;
    // flat grid in x/y with extreme texture values
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++)
        load_pt(j + 3 * k, j << 16, k << 16, 32'h0000_8000,
                (j == 0) ? 32'h7fff_ffff : 32'h8000_0000, (k == 2) ? 32'h7fff_ffff : 0);
    load_pt(9, 1, 2, 3, 4, 5);
    load_pt(15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    eval_at(17'd0, 17'd0);
    eval_at(17'd65536, 17'd65536);
    eval_at(17'd32768, 17'd32768);
    eval_at(17'h1ffff, 17'd1);
    eval_at(17'd65535, 17'h1ffff);
    wait_drained();
  endtask

  task automatic test_degenerate_normal;
    for (int i = 0; i < NUM_POINTS; i++) load_pt(i, 32'h7fff_ffff, 32'h8000_0000, 7, -1, 0);
    eval_at(17'd1000, 17'd50000);
    // collinear points give a zero cross product
    for (int i = 0; i < NUM_POINTS; i++) load_pt(i, i << 16, i << 17, 0, i, -i);
    eval_at(17'd20000, 17'd40000);
    eval_at(17'd65536, 17'd0);
    wait_drained();
  endtask

  task automatic test_backpressure;
    fork
      begin
        rx_hold = 1'b1;
        repeat (600) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    for (int i = 0; i < 12; i++) eval_at(rand_param(), rand_param());
    wait_drained();
  endtask

  task automatic test_random_mix;
    for (int i = 0; i < 1260; i++) begin
      if (i % 150 == 0) rx_stall_pct = $urandom_range(0, 3) * 25;
      if (i % 300 == 299) wait_drained();
      case ($urandom_range(0, 9))
        0, 1: load_pt($urandom_range(0, 8), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord());
        2: load_pt($urandom_range(0, 15), $urandom, $urandom, $urandom, $urandom, $urandom);
        default: eval_at(rand_param(), rand_param());
      endcase
    end
    wait_drained();
  endtask

  // ---------------- receiver and checker ----------------
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
  end

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("result %0d: %s is %0d, expected %0d", n_results, field, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin
    patch_res_t want;
    patch_res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.px = m_tdata[31:0];
      got.py = m_tdata[63:32];
      got.pz = m_tdata[95:64];
      got.ts = m_tdata[127:96];
      got.tt = m_tdata[159:128];
      got.nx = m_tdata[175:160];
      got.ny = m_tdata[191:176];
      got.nz = m_tdata[207:192];
      if (surface_q.size() == 0) begin
        $display("result with no pending evaluate");
        mismatch_cnt++;
      end else begin
        want = surface_q.pop_front();
        if (got.px !== want.px) report_mismatch("point_x", got.px, want.px);
        if (got.py !== want.py) report_mismatch("point_y", got.py, want.py);
        if (got.pz !== want.pz) report_mismatch("point_z", got.pz, want.pz);
        if (got.ts !== want.ts) report_mismatch("tex_s", got.ts, want.ts);
        if (got.tt !== want.tt) report_mismatch("tex_t", got.tt, want.tt);
        if (got.nx !== want.nx) report_mismatch("normal_x", got.nx, want.nx);
        if (got.ny !== want.ny) report_mismatch("normal_y", got.ny, want.ny);
        if (got.nz !== want.nz) report_mismatch("normal_z", got.nz, want.nz);
      end
      n_results++;
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("timeout with %0d results pending", surface_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    rx_hold = 1'b0;
    rx_stall_pct = 30;
    burst_left = 0;
    mismatch_cnt = 0;
    n_loads = 0;
    n_evals = 0;
    n_results = 0;
    n_degenerate = 0;
    foreach (ctrl_mem[i]) ctrl_mem[i] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_degenerate_normal();
    test_backpressure();
    test_random_mix();

    repeat (400) @(posedge clk);
    $display("covered %0d loads and %0d evaluates, %0d results checked, %0d degenerate normals",
             n_loads, n_evals, n_results, n_degenerate);
    $display("with bursty input, random output stalls and one long output hold");
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
